### hdl/aul_pkg.sv
// Shared widths, reset values and register indexes of the audio upsampler.
package aul_pkg;

  localparam int BYTE_W         = 8;
  localparam int PCM_W          = 16;
  localparam int RATIO_W        = 12;
  localparam int LEN_W          = 20;
  localparam int ALPHA_W        = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 20;
  localparam int ACC_W          = 32;
  localparam int SRC_W          = 24;
  localparam int FRAC_W         = 8;
  localparam int COUNT_BITS_DEF = 20;
  localparam int MAX_RUN        = 16;
  localparam int RUN_W          = 5;
  localparam int DIGIT_W        = 4;
  localparam int DIGITS         = ALPHA_W / DIGIT_W;
  localparam int DIGIT_CNT_W    = 2;

  localparam logic [RATIO_W-1:0] RATIO_RST = 12'd57;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 12'd16;
  localparam logic [LEN_W-1:0]   LEN_RST   = 20'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd26870;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_RATIO    = 2'd0,
    REG_OUTPUT_LENGTH = 2'd1,
    REG_FILTER_ALPHA  = 2'd2
  } cfg_reg_t;

endpackage

### hdl/audio_upsampler_lowpass.sv
// Audio upsampler: nearest-neighbor resampling with a one-pole low-pass filter.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   in       | in_valid/in_ready  | in_source_byte
//   out      | out_valid/out_ready| out_pcm_sample, out_last_of_run, out_sound_done
//   cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte at a time: a byte passes the idle and check states, and each output sample
// the multiply, update and emit states. The filter multiply runs radix-16
// serial through alpha, one digit per multiply step, then one update and one emit step.
// Reset (synchronous, rst_n low) returns registers to their defaults, counters to zero.
// An output waiting in the output register stalls only the emit step.
// cfg_ready is always high.
module audio_upsampler_lowpass #(
  parameter int COUNT_BITS = aul_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [aul_pkg::BYTE_W-1:0]       in_source_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [aul_pkg::PCM_W-1:0] out_pcm_sample,
  output logic                             out_last_of_run,
  output logic                             out_sound_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aul_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aul_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aul_pkg::*;

  localparam int WIDE_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
  localparam logic [WIDE_W-1:0] CMASK = (WIDE_W'(1) << COUNT_BITS) - WIDE_W'(1);
  localparam int D_W    = PCM_W + 1;
  localparam int PH_W   = D_W + 1;
  localparam int T_W    = D_W + DIGIT_W + 1;
  localparam int HIGH_W = PH_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_UPD,
    ST_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [RATIO_W-1:0]        ratio_r, ratio_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [ALPHA_W-1:0]        alpha_r, alpha_nxt;
  logic [COUNT_BITS-1:0]     count_r, count_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [SRC_W-1:0]          src_r, src_nxt;
  logic signed [PCM_W-1:0]   prev_r, prev_nxt;
  logic [BYTE_W-1:0]         byte_r, byte_nxt;
  logic [RUN_W-1:0]          run_r, run_nxt;
  logic                      first_r, first_nxt;
  logic [ALPHA_W-1:0]        alpha_sr_r, alpha_sr_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic [DIGIT_CNT_W-1:0]    digit_cnt_r, digit_cnt_nxt;
  logic signed [PH_W-1:0]    p_hi_r, p_hi_nxt;
  logic [ALPHA_W-1:0]        low_r, low_nxt;
  logic signed [PCM_W-1:0]   y_r, y_nxt;
  logic                      done_r, done_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [PCM_W-1:0]   out_pcm_r, out_pcm_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_done_r, out_done_nxt;

  logic signed [PCM_W-1:0]   x;
  logic signed [D_W-1:0]     d_new;
  logic [RATIO_W-1:0]        ratio_eff;
  logic [WIDE_W-1:0]         count_w, len_w, limit_w;
  logic                      go;
  logic signed [T_W-1:0]     t_sum;
  logic signed [HIGH_W-1:0]  high, y_fl;
  logic signed [PCM_W-1:0]   y_sel;

  assign x         = {~byte_r[BYTE_W-1], byte_r[BYTE_W-2:0], byte_r};
  assign d_new     = D_W'(x) - D_W'(prev_r);
  assign ratio_eff = (ratio_r < RATIO_MIN) ? RATIO_MIN : ratio_r;
  assign count_w   = WIDE_W'(count_r);
  assign len_w     = WIDE_W'(len_r);
  assign limit_w   = (len_w > CMASK) ? CMASK : len_w;
  assign go        = (run_r != RUN_W'(MAX_RUN)) && (count_w < limit_w) &&
                     (acc_r[ACC_W-1:FRAC_W] == src_r);

  assign t_sum = T_W'(p_hi_r) + T_W'(d_r) * T_W'($signed({1'b0, alpha_sr_r[DIGIT_W-1:0]}));
  assign high  = HIGH_W'(prev_r) + HIGH_W'(p_hi_r);
  assign y_fl  = (high[HIGH_W-1] && (low_r != '0)) ? high + HIGH_W'(1) : high;
  assign y_sel = first_r ? x : y_fl[PCM_W-1:0];

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_pcm_sample  = out_pcm_r;
  assign out_last_of_run = out_last_r;
  assign out_sound_done  = out_done_r;

  always_comb begin
    state_nxt     = state_r;
    ratio_nxt     = ratio_r;
    len_nxt       = len_r;
    alpha_nxt     = alpha_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    src_nxt       = src_r;
    prev_nxt      = prev_r;
    byte_nxt      = byte_r;
    run_nxt       = run_r;
    first_nxt     = first_r;
    alpha_sr_nxt  = alpha_sr_r;
    d_nxt         = d_r;
    digit_cnt_nxt = digit_cnt_r;
    p_hi_nxt      = p_hi_r;
    low_nxt       = low_r;
    y_nxt         = y_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_pcm_nxt   = out_pcm_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_RATIO:    ratio_nxt = cfg_data[RATIO_W-1:0];
        REG_OUTPUT_LENGTH: len_nxt   = cfg_data[LEN_W-1:0];
        REG_FILTER_ALPHA:  alpha_nxt = cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_source_byte;
          run_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go) begin
          alpha_sr_nxt  = alpha_r;
          d_nxt         = d_new;
          p_hi_nxt      = '0;
          digit_cnt_nxt = '0;
          first_nxt     = (count_r == '0);
          state_nxt     = ST_MUL;
        end else begin
          src_nxt   = src_r + SRC_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        p_hi_nxt      = t_sum[T_W-1:DIGIT_W];
        low_nxt       = {t_sum[DIGIT_W-1:0], low_r[ALPHA_W-1:DIGIT_W]};
        alpha_sr_nxt  = alpha_sr_r >> DIGIT_W;
        digit_cnt_nxt = digit_cnt_r + DIGIT_CNT_W'(1);
        if (digit_cnt_r == DIGIT_CNT_W'(DIGITS - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        y_nxt     = y_sel;
        prev_nxt  = y_sel;
        done_nxt  = ((count_w + WIDE_W'(1)) == limit_w);
        acc_nxt   = acc_r + ACC_W'(ratio_eff);
        count_nxt = count_r + COUNT_BITS'(1);
        run_nxt   = run_r + RUN_W'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pcm_nxt   = y_r;
          out_last_nxt  = !go;
          out_done_nxt  = done_r;
          if (go) begin
            alpha_sr_nxt  = alpha_r;
            d_nxt         = d_new;
            p_hi_nxt      = '0;
            digit_cnt_nxt = '0;
            first_nxt     = (count_r == '0);
            state_nxt     = ST_MUL;
          end else begin
            src_nxt   = src_r + SRC_W'(1);
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ratio_r     <= RATIO_RST;
      len_r       <= LEN_RST;
      alpha_r     <= ALPHA_RST;
      count_r     <= '0;
      acc_r       <= '0;
      src_r       <= '0;
      prev_r      <= '0;
      run_r       <= '0;
      first_r     <= 1'b0;
      digit_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_r     <= ratio_nxt;
      len_r       <= len_nxt;
      alpha_r     <= alpha_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      src_r       <= src_nxt;
      prev_r      <= prev_nxt;
      run_r       <= run_nxt;
      first_r     <= first_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    alpha_sr_r <= alpha_sr_nxt;
    d_r        <= d_nxt;
    p_hi_r     <= p_hi_nxt;
    low_r      <= low_nxt;
    y_r        <= y_nxt;
    done_r     <= done_nxt;
    out_pcm_r  <= out_pcm_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

### hdl/aul_checker.sv
// Port-level checker for the audio upsampler, bound to the top level.
module aul_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [aul_pkg::PCM_W-1:0] out_pcm_sample,
  input logic                             out_last_of_run,
  input logic                             out_sound_done,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import aul_pkg::*;

  logic [RUN_W-1:0] run_r, run_nxt;
  logic             seen_done_r, seen_done_nxt;

  always_comb begin
    run_nxt       = run_r;
    seen_done_nxt = seen_done_r;
    if (out_valid && out_ready) begin
      run_nxt = out_last_of_run ? '0 : run_r + RUN_W'(1);
      if (out_sound_done) begin
        seen_done_nxt = 1'b1;
      end
    end
    if (cfg_valid && cfg_ready) begin
      seen_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      seen_done_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      seen_done_r <= seen_done_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pcm_sample) &&
      $stable(out_last_of_run) && $stable(out_sound_done))
    else $error("output item changed while stalled");

  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second byte taken while one is in work");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (run_r == RUN_W'(MAX_RUN - 1)) |-> out_last_of_run)
    else $error("run of outputs from one byte too long");

  a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    seen_done_r |-> !out_valid)
    else $error("output after end of sound");

endmodule

bind audio_upsampler_lowpass aul_checker u_aul_checker (.*);

### tb/audio_upsampler_lowpass_tb.sv
// Testbench for audio_upsampler_lowpass: random traffic checked against a resampler/filter model.
`timescale 1ns / 100ps

module audio_upsampler_lowpass_tb;
  import aul_pkg::*;

  localparam int     LIMIT_CYCLES = 600000;
  localparam int     SETTLE       = 64;
  localparam int     PCM_OFFSET   = 32768;
  localparam longint ALPHA_ONE    = 65536;
  localparam logic [LEN_W-1:0] LEN_MAX    = '1;
  localparam logic [63:0]      EDGE_BYTES = 64'h00FF807F01FE55AA;
  localparam cfg_reg_t         REG_SPARE  = cfg_reg_t'(2'd3);

  typedef struct packed {
    logic [PCM_W-1:0] pcm;
    logic             last;
    logic             done;
  } pcm_expect_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_source_byte = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic signed [PCM_W-1:0] out_pcm_sample;
  logic                  out_last_of_run;
  logic                  out_sound_done;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index      = REG_STEP_RATIO;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // model state
  logic [RATIO_W-1:0] ratio_reg  = RATIO_RST;
  logic [LEN_W-1:0]   length_reg = LEN_RST;
  logic [ALPHA_W-1:0] alpha_reg  = ALPHA_RST;
  logic [LEN_W-1:0]   produced   = '0;
  logic [ACC_W-1:0]   pos_acc    = '0;
  logic [SRC_W-1:0]   src_idx    = '0;
  int                 prev_pcm   = 0;

  pcm_expect_t       pcm_expect[$];
  logic [BYTE_W-1:0] pending_bytes[$];
  int  queued_bytes   = 0;
  int  accepted_bytes = 0;
  int  samples_checked = 0;
  int  reg_writes     = 0;
  int  sound_ends     = 0;
  int  errors         = 0;
  int  cycles         = 0;
  int  send_gap       = 0;
  int  recv_gap       = 0;
  bit  in_taken       = 1'b0;
  bit  idle_on        = 1'b1;

  audio_upsampler_lowpass dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_byte (in_source_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pcm_sample (out_pcm_sample),
    .out_last_of_run(out_last_of_run),
    .out_sound_done (out_sound_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int smooth(int x);
    longint a;
    longint acc;
    a   = longint'(alpha_reg);
    acc = a * x + (ALPHA_ONE - a) * prev_pcm;
    return int'(acc / ALPHA_ONE);
  endfunction

  // nearest-neighbor upsample of one source byte, then low-pass
  function automatic void resample_byte(logic [BYTE_W-1:0] b);
    logic [RATIO_W-1:0] step;
    pcm_expect_t held;
    int x;
    int y;
    int n;
    x    = int'({b, b}) - PCM_OFFSET;
    step = (ratio_reg < RATIO_MIN) ? RATIO_MIN : ratio_reg;
    n    = 0;
    while (n < MAX_RUN && produced < length_reg && pos_acc[ACC_W-1:FRAC_W] == src_idx) begin
      y = (produced == '0) ? x : smooth(x);
      prev_pcm = y;
      if (n > 0) begin
        pcm_expect.push_back(held);
      end
      held.pcm  = y[PCM_W-1:0];
      held.last = 1'b0;
      held.done = (produced == length_reg - 1'b1);
      if (held.done) begin
        sound_ends++;
      end
      pos_acc  = pos_acc + ACC_W'(step);
      produced = produced + 1'b1;
      n++;
    end
    if (n > 0) begin
      held.last = 1'b1;
      pcm_expect.push_back(held);
    end
    src_idx = src_idx + 1'b1;
  endfunction

  task automatic queue_byte(logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    queued_bytes++;
  endtask

  task automatic wait_idle();
    while (accepted_bytes != queued_bytes || pcm_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return BYTE_W'($urandom);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_source_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) begin
          recv_gap = $urandom_range(1, 14);
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pcm_expect_t want;
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pcm_expect.size() == 0) begin
          report($sformatf("unexpected sample %0d", out_pcm_sample));
        end else begin
          want = pcm_expect.pop_front();
          samples_checked++;
          if (out_pcm_sample !== want.pcm) begin
            report($sformatf("pcm_sample %0d, want %0d", out_pcm_sample, $signed(want.pcm)));
          end
          if (out_last_of_run !== want.last) begin
            report($sformatf("last_of_run %b, want %b", out_last_of_run, want.last));
          end
          if (out_sound_done !== want.done) begin
            report($sformatf("sound_done %b, want %b", out_sound_done, want.done));
          end
        end
      end
      if (in_taken) begin
        resample_byte(in_source_byte);
        accepted_bytes++;
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_STEP_RATIO:    ratio_reg  = cfg_data[RATIO_W-1:0];
          REG_OUTPUT_LENGTH: length_reg = cfg_data[LEN_W-1:0];
          REG_FILTER_ALPHA:  alpha_reg  = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int k;
    int ph;
    logic [RATIO_W-1:0] r;
    logic [ALPHA_W-1:0] a;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset ratio and alpha, longest sound; first sample passes unfiltered
    write_reg(REG_OUTPUT_LENGTH, CFG_DATA_W'(LEN_MAX));
    for (k = 0; k < 8; k++) begin
      queue_byte(EDGE_BYTES[63 - 8*k -: 8]);
    end
    // ratio below minimum, full-scale alpha
    write_reg(REG_STEP_RATIO, '0);
    write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(16'hFFFF));
    queue_byte(8'hFF);
    queue_byte(8'h00);
    // zero alpha holds the previous sample
    write_reg(REG_STEP_RATIO, CFG_DATA_W'(RATIO_MIN - 1'b1));
    write_reg(REG_FILTER_ALPHA, '0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    // largest ratio, smallest nonzero alpha
    write_reg(REG_STEP_RATIO, CFG_DATA_W'(12'hFFF));
    write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(1));
    for (k = 0; k < 6; k++) begin
      queue_byte(k[0] ? 8'hFF : 8'h00);
    end

    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 4))
        0:       r = RATIO_W'($urandom_range(0, 16));
        1:       r = RATIO_W'($urandom_range(17, 127));
        2:       r = RATIO_W'($urandom_range(128, 1023));
        3:       r = RATIO_W'($urandom_range(1024, 4095));
        default: r = RATIO_W'($urandom_range(40, 80));
      endcase
      case ($urandom_range(0, 4))
        0:       a = '0;
        1:       a = '1;
        2:       a = ALPHA_W'(1);
        default: a = ALPHA_W'($urandom);
      endcase
      write_reg(REG_STEP_RATIO, {8'($urandom), r});
      write_reg(REG_FILTER_ALPHA, {4'($urandom), a});
      if (ph == 2) begin
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      end
      for (k = 0; k < 32; k++) begin
        queue_byte(pick_byte());
      end
    end

    // end of sound, bytes after the end, zero and lowered length
    idle_on = 1'b0;
    write_reg(REG_STEP_RATIO, CFG_DATA_W'(64));
    write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(ALPHA_RST));
    write_reg(REG_OUTPUT_LENGTH, CFG_DATA_W'(produced + LEN_W'(7)));
    for (k = 0; k < 6; k++) begin
      queue_byte(pick_byte());
    end
    write_reg(REG_OUTPUT_LENGTH, '0);
    for (k = 0; k < 3; k++) begin
      queue_byte(pick_byte());
    end
    write_reg(REG_OUTPUT_LENGTH, CFG_DATA_W'(produced >> 1));
    for (k = 0; k < 3; k++) begin
      queue_byte(pick_byte());
    end
    wait_idle();

    $display("Covered %0d source bytes over %0d register writes, ratios from below minimum to max.",
             accepted_bytes, reg_writes);
    $display("Checked %0d output samples, %0d end-of-sound flags, %0d mismatches.",
             samples_checked, sound_ends, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
